// ----- hw/rtl/gha_pkg.sv -----
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants of the generational handle allocator: action
// codes, handle field positions, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package gha_pkg;

	// Handle layout: index in bits 15:0, generation in 23:16, flags in 31:24.
	localparam int HANDLE_W    = 32;
	localparam int HIDX_W      = 16;
	localparam int GEN_W       = 8;
	localparam int GEN_LSB     = 16;
	localparam int FLAG_LSB    = 24;
	localparam int ALIVE_W     = 11;
	localparam int ACTION_W    = 3;
	localparam int SLOT_IDX_W  = 10;

	localparam logic [HANDLE_W-1:0] INVALID_HANDLE = 32'hFFFF_FFFF;
	localparam logic [HANDLE_W-1:0] FLAG_FIELD     = 32'hFF00_0000;

	// Operation codes carried on the input tuser.
	typedef enum logic [ACTION_W-1:0] {
		ACT_CREATE  = 3'd0,
		ACT_DESTROY = 3'd1,
		ACT_QUERY   = 3'd2,
		ACT_SET     = 3'd3,
		ACT_RESET   = 3'd4,
		ACT_CLEAR   = 3'd5
	} action_t;

	// Controller states.
	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;  // latch the request and read its slot entry
		logic commit;   // update state, write back and load the result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_busy; // output register holds a result not taken this cycle
	} status_t;

endpackage

// ----- hw/rtl/gha_ram.sv -----
// ----------------------------------------------------------------------------
// gha_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/gha_ctrl.sv -----
// ----------------------------------------------------------------------------
// gha_ctrl
// Controller of the handle allocator. Takes one request in idle, then waits
// in the execute state until the output register can take the result.
// ----------------------------------------------------------------------------
module gha_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  gha_pkg::status_t st,
	output gha_pkg::cmd_t    cmd
);

	gha_pkg::state_t state_q;
	gha_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gha_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			gha_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = gha_pkg::ST_EXEC;
				end
			end
			gha_pkg::ST_EXEC: begin
				if (!st.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = gha_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gha_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/gha_datapath.sv -----
// ----------------------------------------------------------------------------
// gha_datapath
// Datapath of the handle allocator: request registers, slot table, free-list
// head, fresh-slot counter, live count and the output register.
// ----------------------------------------------------------------------------
module gha_datapath #(
	parameter int MAX_SLOTS      = 1024,
	parameter int MAX_GENERATION = 255
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gha_pkg::cmd_t                       cmd,
	output gha_pkg::status_t                    st,
	input  logic [gha_pkg::ACTION_W-1:0]        in_action,
	input  logic [gha_pkg::HANDLE_W-1:0]        in_handle,
	input  logic [gha_pkg::SLOT_IDX_W-1:0]      in_slot_index,
	input  logic [gha_pkg::HANDLE_W-1:0]        in_flag_mask,
	output logic [gha_pkg::HANDLE_W-1:0]        out_value,
	output logic                                out_ok,
	output logic [gha_pkg::ALIVE_W-1:0]         out_alive,
	output logic                                out_valid,
	input  logic                                out_ready
);

	localparam int CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int IDX_W = $clog2(MAX_SLOTS);

	// Latched request.
	logic [gha_pkg::ACTION_W-1:0]   action_q;
	logic [gha_pkg::HANDLE_W-1:0]   handle_q;
	logic [gha_pkg::SLOT_IDX_W-1:0] sidx_q;
	logic [gha_pkg::HANDLE_W-1:0]   mask_q;

	// Allocator state.
	logic [CNT_W-1:0] fresh_q, fresh_d;
	logic [CNT_W-1:0] head_q, head_d;
	logic [CNT_W-1:0] alive_q, alive_d;

	// Output register.
	logic [gha_pkg::HANDLE_W-1:0] value_q, value_d;
	logic                         ok_q, ok_d;
	logic [gha_pkg::ALIVE_W-1:0]  alive_out_q;
	logic                         out_valid_q;

	// Slot table ports.
	logic                         ram_we;
	logic [IDX_W-1:0]             ram_waddr;
	logic [gha_pkg::HANDLE_W-1:0] ram_wdata;
	logic [IDX_W-1:0]             ram_raddr;
	logic [gha_pkg::HANDLE_W-1:0] entry;

	// Decoded fields of the latched request and the entry read.
	logic [gha_pkg::HIDX_W-1:0] h_idx;
	logic [gha_pkg::GEN_W-1:0]  h_gen;
	logic [gha_pkg::HIDX_W-1:0] e_idx;
	logic [gha_pkg::GEN_W-1:0]  e_gen;
	logic [gha_pkg::GEN_W:0]    next_gen;
	logic                       h_valid;
	logic                       list_empty;
	logic                       sidx_live;
	logic [gha_pkg::HANDLE_W-1:0] flag_mask;
	logic [gha_pkg::HANDLE_W-1:0] flag_entry;

	gha_ram #(
		.WIDTH (gha_pkg::HANDLE_W),
		.DEPTH (MAX_SLOTS)
	) u_slot_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.capture),
		.raddr (ram_raddr),
		.rdata (entry)
	);

	// Read address: free-list head for create, the handle's index for destroy
	// and query, the slot index for flag operations.
	always_comb begin
		unique case (in_action)
			gha_pkg::ACT_CREATE:  ram_raddr = IDX_W'(head_q);
			gha_pkg::ACT_DESTROY,
			gha_pkg::ACT_QUERY:   ram_raddr = IDX_W'(in_handle[gha_pkg::HIDX_W-1:0]);
			default:              ram_raddr = IDX_W'(in_slot_index);
		endcase
	end

	// Request registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= in_action;
			handle_q <= in_handle;
			sidx_q   <= in_slot_index;
			mask_q   <= in_flag_mask;
		end
	end

	// Field decode and validity check of the latched handle.
	assign h_idx      = handle_q[gha_pkg::HIDX_W-1:0];
	assign h_gen      = handle_q[gha_pkg::GEN_LSB +: gha_pkg::GEN_W];
	assign e_idx      = entry[gha_pkg::HIDX_W-1:0];
	assign e_gen      = entry[gha_pkg::GEN_LSB +: gha_pkg::GEN_W];
	assign next_gen   = {1'b0, h_gen} + 9'd1;
	assign list_empty = (head_q == CNT_W'(MAX_SLOTS));
	assign sidx_live  = (16'(sidx_q) < 16'(fresh_q));
	assign h_valid    = (handle_q != gha_pkg::INVALID_HANDLE)
		&& (h_idx < 16'(fresh_q)) && (e_idx == h_idx) && (e_gen == h_gen)
		&& (h_gen < 8'(MAX_GENERATION));
	assign flag_mask  = mask_q & gha_pkg::FLAG_FIELD;

	// New entry word for the flag operations.
	always_comb begin
		unique case (action_q)
			gha_pkg::ACT_SET:   flag_entry = entry | flag_mask;
			gha_pkg::ACT_RESET: flag_entry = entry & ~flag_mask;
			default:            flag_entry = entry & ~gha_pkg::FLAG_FIELD;
		endcase
	end

	// Operation: next state, write back and result.
	always_comb begin
		fresh_d   = fresh_q;
		head_d    = head_q;
		alive_d   = alive_q;
		value_d   = '0;
		ok_d      = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = IDX_W'(sidx_q);
		ram_wdata = flag_entry;
		unique case (action_q)
			gha_pkg::ACT_CREATE: begin
				if (!list_empty) begin
					// Pop the free-list head, keeping its generation.
					ram_we    = 1'b1;
					ram_waddr = IDX_W'(head_q);
					ram_wdata = {8'h00, e_gen, 16'(head_q)};
					value_d   = {8'h00, e_gen, 16'(head_q)};
					ok_d      = 1'b1;
					head_d    = e_idx[CNT_W-1:0];
					alive_d   = alive_q + CNT_W'(1);
				end else if (fresh_q != CNT_W'(MAX_SLOTS)) begin
					// Take a slot never used before.
					ram_we    = 1'b1;
					ram_waddr = IDX_W'(fresh_q);
					ram_wdata = 32'(fresh_q);
					value_d   = 32'(fresh_q);
					ok_d      = 1'b1;
					fresh_d   = fresh_q + CNT_W'(1);
					alive_d   = alive_q + CNT_W'(1);
				end else begin
					value_d = gha_pkg::INVALID_HANDLE;
				end
			end
			gha_pkg::ACT_DESTROY: begin
				if (h_valid) begin
					ram_we    = 1'b1;
					ram_waddr = IDX_W'(h_idx);
					ok_d      = 1'b1;
					if (next_gen < 9'(MAX_GENERATION)) begin
						// Push onto the free list with the bumped generation.
						ram_wdata = {8'h00, next_gen[gha_pkg::GEN_W-1:0], 16'(head_q)};
						head_d    = CNT_W'(h_idx);
					end else begin
						// Retired: the entry keeps its index at the top generation.
						ram_wdata = {8'h00, 8'(MAX_GENERATION), h_idx};
					end
					if (alive_q != '0) begin
						alive_d = alive_q - CNT_W'(1);
					end
				end
			end
			gha_pkg::ACT_QUERY: begin
				ok_d = h_valid;
			end
			gha_pkg::ACT_SET,
			gha_pkg::ACT_RESET,
			gha_pkg::ACT_CLEAR: begin
				if (sidx_live) begin
					ram_we  = 1'b1;
					value_d = flag_entry;
					ok_d    = 1'b1;
				end else begin
					value_d = gha_pkg::INVALID_HANDLE;
				end
			end
			default: begin
				value_d = '0;
			end
		endcase
		ram_we = ram_we && cmd.commit;
	end

	// Allocator state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= '0;
			head_q  <= CNT_W'(MAX_SLOTS);
			alive_q <= '0;
		end else if (cmd.commit) begin
			fresh_q <= fresh_d;
			head_q  <= head_d;
			alive_q <= alive_d;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			value_q     <= value_d;
			ok_q        <= ok_d;
			alive_out_q <= gha_pkg::ALIVE_W'(alive_d);
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign st.out_busy = out_valid_q && !out_ready;
	assign out_value   = value_q;
	assign out_ok      = ok_q;
	assign out_alive   = alive_out_q;
	assign out_valid   = out_valid_q;

endmodule

// ----- hw/rtl/generational_handle_allocator.sv -----
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Allocator of 32-bit generational handles over a slot table, with create,
// destroy, validity query and flag operations on slot entries.
// ----------------------------------------------------------------------------
// A request first reads its slot entry from the slot table RAM (registered
// read port), then updates the allocator state, writes the entry back and
// loads the result register. A request is taken only when the previous one
// has finished its write back; the update waits while the output register
// still holds a result that the sink has not taken. The slot table needs no
// initialization after reset, so the block takes requests as soon as reset
// is released. A handle is index (15:0), generation (23:16) and flags
// (31:24); the all-ones word is the invalid handle.
// ----------------------------------------------------------------------------
module generational_handle_allocator #(
	parameter int MAX_SLOTS      = 1024,
	parameter int MAX_GENERATION = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // handle[31:0], slot_index[41:32], flag_mask[73:42], zeros
	input  logic [2:0]  s_tuser,  // action[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // value[31:0], ok[32], alive_count[43:33], zeros
);

	gha_pkg::cmd_t    cmd;
	gha_pkg::status_t st;

	logic [gha_pkg::HANDLE_W-1:0] out_value;
	logic                         out_ok;
	logic [gha_pkg::ALIVE_W-1:0]  out_alive;

	gha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	gha_datapath #(
		.MAX_SLOTS      (MAX_SLOTS),
		.MAX_GENERATION (MAX_GENERATION)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.in_action     (s_tuser),
		.in_handle     (s_tdata[31:0]),
		.in_slot_index (s_tdata[41:32]),
		.in_flag_mask  (s_tdata[73:42]),
		.out_value     (out_value),
		.out_ok        (out_ok),
		.out_alive     (out_alive),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready)
	);

	// Pack the result beat.
	assign m_tdata = {4'h0, out_alive, out_ok, out_value};

`ifndef NO_ASSERTIONS
	// A request is never taken in the cycle after another one was taken.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while the previous one is in flight");

	// The live count never exceeds the number of slots.
	a_alive_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[43:33]) <= 32'(MAX_SLOTS)))
		else $error("live count above slot count");

	// A failed operation answers with zero or the invalid handle only.
	a_fail_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[32] |->
			(m_tdata[31:0] == 32'h0) || (m_tdata[31:0] == 32'hFFFF_FFFF))
		else $error("failed operation with a stray value");

	// A successful result never carries an index beyond the empty-list mark.
	a_ok_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[32] |-> (32'(m_tdata[15:0]) <= 32'(MAX_SLOTS)))
		else $error("successful result with an index out of range");
`endif

endmodule
